### rtl/motor_start_brake_sequencer_core_defines.svh
// assertion macros for the sequencer checker
`ifndef MOTOR_START_BRAKE_SEQUENCER_CORE_DEFINES_SVH
`define MOTOR_START_BRAKE_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MSB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define MSB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

### rtl/msb_pkg.sv
package msb_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int ADC_W          = 12;
  localparam int CFG_W          = 16;
  localparam int PWM_W          = 16;
  localparam int CFG_IDX_W      = 3;

  localparam logic [ADC_W-1:0] STOP_THR_RST   = 12'd1800;
  localparam logic [ADC_W-1:0] FAULT_THR_RST  = 12'd2500;
  localparam logic [CFG_W-1:0] START_TO_RST   = 16'd8000;
  localparam logic [CFG_W-1:0] BRAKE_STEP_RST = 16'd350;
  localparam logic [CFG_W-1:0] BRAKE_INT_RST  = 16'd50;
  localparam logic [CFG_W-1:0] STOP_HOLD_RST  = 16'd50;
  localparam logic [CFG_W-1:0] RUN_HOLD_RST   = 16'd30;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_WAIT  = 2'd1,
    PH_LOOP  = 2'd2,
    PH_ERR   = 2'd3
  } main_phase_t;

  typedef enum logic [1:0] {
    PR_FIRST  = 2'd0,
    PR_SECOND = 2'd1,
    PR_ERR    = 2'd2,
    PR_DONE   = 2'd3
  } prep_phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STOP_THR   = 3'd0,
    REG_FAULT_THR  = 3'd1,
    REG_START_TO   = 3'd2,
    REG_BRAKE_STEP = 3'd3,
    REG_BRAKE_INT  = 3'd4,
    REG_STOP_HOLD  = 3'd5,
    REG_RUN_HOLD   = 3'd6
  } cfg_idx_t;

endpackage

### rtl/msb_in_if.sv
interface msb_in_if import msb_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [ADC_W-1:0] stop_sense;
  logic [ADC_W-1:0] fault_sense;
  logic [PWM_W-1:0] pwm_now;

  modport source (output valid, output stop_sense, output fault_sense, output pwm_now,
                  input ready);
  modport sink   (input valid, input stop_sense, input fault_sense, input pwm_now,
                  output ready);
endinterface

### rtl/msb_out_if.sv
interface msb_out_if import msb_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [PWM_W-1:0] pwm_next;
  logic             start_cmd;
  logic             stop_cmd;
  logic             braked;
  logic             loop_enable;
  logic             error_on;
  logic [1:0]       main_phase;
  logic [1:0]       prep_phase;

  modport source (output valid, output pwm_next, output start_cmd, output stop_cmd,
                  output braked, output loop_enable, output error_on,
                  output main_phase, output prep_phase, input ready);
  modport sink   (input valid, input pwm_next, input start_cmd, input stop_cmd,
                  input braked, input loop_enable, input error_on,
                  input main_phase, input prep_phase, output ready);
endinterface

### rtl/msb_cfg_if.sv
interface msb_cfg_if import msb_pkg::*; ;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/motor_start_brake_sequencer_core.sv
// result path: the input transaction is held in the input register, then in the result register
// throughput: one transaction per cycle while out_ch.ready is high, no bubbles; set by the single-pass state update
// output register lets a new input be taken while a result waits on out_ch.ready
// reset: synchronous active-low rst_n restores register defaults, start-up/first phases,
// clears timers, flags and both pipeline valids
module motor_start_brake_sequencer_core import msb_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  msb_in_if.sink    in_ch,
  msb_out_if.source out_ch,
  msb_cfg_if.sink   cfg_ch
);

  localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] TMR_MAX = {TIMER_BITS{1'b1}};

  logic [ADC_W-1:0] stop_thr_r, fault_thr_r;
  logic [CFG_W-1:0] start_to_r, brake_step_r, brake_int_r, stop_hold_r, run_hold_r;

  logic             s1_valid_r;
  logic [ADC_W-1:0] s1_stop_r, s1_fault_r;
  logic [PWM_W-1:0] s1_pwm_r;

  main_phase_t main_r, main_nxt;
  prep_phase_t prep_r, prep_nxt;
  logic        loop_r, loop_nxt;
  logic        braked_r, braked_nxt;
  logic [TIMER_BITS-1:0] startup_r, brake_r, hold_r;
  logic [TIMER_BITS-1:0] startup_nxt, brake_nxt, hold_nxt;

  logic             out_valid_r;
  logic [PWM_W-1:0] out_pwm_r;
  logic             out_start_r, out_stop_r, out_braked_r, out_loop_r, out_err_r;
  logic [1:0]       out_main_r, out_prep_r;

  logic out_free, adv, in_acc;
  logic stop_f, fault_f;
  logic start_ok, brake_due, stop_held, run_held;
  logic [PWM_W-1:0] pwm_w, pwm_dec;
  logic start_cmd, stop_cmd, err_on, clr_brake, clr_hold, braked_set, loop_set, loop_clr;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign adv         = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign stop_f  = s1_stop_r > stop_thr_r;
  assign fault_f = !(s1_fault_r < fault_thr_r);

  assign start_ok  = CW'(startup_r) <  CW'(start_to_r);
  assign brake_due = CW'(brake_r)   >= CW'(brake_int_r);
  assign stop_held = CW'(hold_r)    >  CW'(stop_hold_r);
  assign run_held  = CW'(hold_r)    >  CW'(run_hold_r);
  assign pwm_dec   = s1_pwm_r - brake_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_thr_r   <= STOP_THR_RST;
      fault_thr_r  <= FAULT_THR_RST;
      start_to_r   <= START_TO_RST;
      brake_step_r <= BRAKE_STEP_RST;
      brake_int_r  <= BRAKE_INT_RST;
      stop_hold_r  <= STOP_HOLD_RST;
      run_hold_r   <= RUN_HOLD_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        REG_STOP_THR:   stop_thr_r   <= cfg_ch.data[ADC_W-1:0];
        REG_FAULT_THR:  fault_thr_r  <= cfg_ch.data[ADC_W-1:0];
        REG_START_TO:   start_to_r   <= cfg_ch.data;
        REG_BRAKE_STEP: brake_step_r <= cfg_ch.data;
        REG_BRAKE_INT:  brake_int_r  <= cfg_ch.data;
        REG_STOP_HOLD:  stop_hold_r  <= cfg_ch.data;
        REG_RUN_HOLD:   run_hold_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    main_nxt = main_r;
    prep_nxt = prep_r;
    unique case (main_r)
      PH_START: begin
        unique case (prep_r)
          PR_FIRST: begin
            if (start_ok) begin
              if (!fault_f) prep_nxt = PR_SECOND;
            end else begin
              prep_nxt = PR_ERR;
            end
          end
          PR_SECOND: begin
            if (start_ok) begin
              if (stop_f) begin
                prep_nxt = PR_DONE;
                main_nxt = PH_WAIT;
              end
            end else begin
              prep_nxt = PR_ERR;
            end
          end
          PR_ERR, PR_DONE: ;
        endcase
      end
      PH_WAIT: begin
        if (fault_f) main_nxt = PH_ERR;
        if (!stop_f) main_nxt = PH_LOOP;
      end
      PH_LOOP: begin
        if (fault_f) main_nxt = PH_ERR;
        if (stop_f && stop_held) main_nxt = PH_WAIT;
      end
      PH_ERR: ;
    endcase
  end

  // outputs
  always_comb begin
    pwm_w      = s1_pwm_r;
    start_cmd  = 1'b0;
    stop_cmd   = 1'b0;
    err_on     = 1'b0;
    clr_brake  = 1'b0;
    clr_hold   = 1'b0;
    braked_set = 1'b0;
    loop_set   = 1'b0;
    loop_clr   = 1'b0;
    unique case (main_r)
      PH_START: begin
        if (prep_r == PR_SECOND && start_ok && stop_f) stop_cmd = 1'b1;
        if (prep_r == PR_ERR) begin
          err_on   = 1'b1;
          stop_cmd = 1'b1;
        end
      end
      PH_WAIT: begin
        if (stop_f) begin
          if (brake_due) begin
            clr_brake = 1'b1;
            if (s1_pwm_r > brake_step_r) pwm_w = pwm_dec;
          end
          if (pwm_w <= brake_step_r) begin
            stop_cmd   = 1'b1;
            braked_set = 1'b1;
          end
        end else begin
          start_cmd = 1'b1;
          clr_hold  = 1'b1;
        end
      end
      PH_LOOP: begin
        if (stop_f) begin
          if (stop_held) begin
            clr_hold  = 1'b1;
            loop_clr  = 1'b1;
            clr_brake = 1'b1;
          end
        end else if (run_held) begin
          clr_hold = 1'b1;
          loop_set = 1'b1;
        end
      end
      PH_ERR: begin
        err_on   = 1'b1;
        stop_cmd = 1'b1;
      end
    endcase
  end

  always_comb begin
    braked_nxt  = braked_r | braked_set;
    loop_nxt    = loop_set ? 1'b1 : (loop_clr ? 1'b0 : loop_r);
    startup_nxt = (startup_r == TMR_MAX) ? startup_r : TIMER_BITS'(startup_r + 1'b1);
    brake_nxt   = clr_brake ? '0 :
                  ((brake_r == TMR_MAX) ? brake_r : TIMER_BITS'(brake_r + 1'b1));
    hold_nxt    = clr_hold ? '0 :
                  ((hold_r == TMR_MAX) ? hold_r : TIMER_BITS'(hold_r + 1'b1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      main_r      <= PH_START;
      prep_r      <= PR_FIRST;
      loop_r      <= 1'b0;
      braked_r    <= 1'b0;
      startup_r   <= '0;
      brake_r     <= '0;
      hold_r      <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        main_r      <= main_nxt;
        prep_r      <= prep_nxt;
        loop_r      <= loop_nxt;
        braked_r    <= braked_nxt;
        startup_r   <= startup_nxt;
        brake_r     <= brake_nxt;
        hold_r      <= hold_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_stop_r  <= in_ch.stop_sense;
      s1_fault_r <= in_ch.fault_sense;
      s1_pwm_r   <= in_ch.pwm_now;
    end
    if (adv) begin
      out_pwm_r    <= pwm_w;
      out_start_r  <= start_cmd;
      out_stop_r   <= stop_cmd;
      out_braked_r <= braked_nxt;
      out_loop_r   <= loop_nxt;
      out_err_r    <= err_on;
      out_main_r   <= main_nxt;
      out_prep_r   <= prep_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pwm_next    = out_pwm_r;
  assign out_ch.start_cmd   = out_start_r;
  assign out_ch.stop_cmd    = out_stop_r;
  assign out_ch.braked      = out_braked_r;
  assign out_ch.loop_enable = out_loop_r;
  assign out_ch.error_on    = out_err_r;
  assign out_ch.main_phase  = out_main_r;
  assign out_ch.prep_phase  = out_prep_r;

endmodule

### rtl/msb_checker.sv
`include "motor_start_brake_sequencer_core_defines.svh"

module msb_checker import msb_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PWM_W-1:0] pwm_next,
  input logic             start_cmd,
  input logic             stop_cmd,
  input logic             error_on,
  input logic [1:0]       main_phase,
  input logic [1:0]       prep_phase
);

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  `MSB_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(pwm_next) && $stable(main_phase))
  `MSB_ASSERT_NOW(a_err_stops, out_valid && error_on, stop_cmd)
  `MSB_ASSERT_NOW(a_err_phase, out_valid && error_on, main_phase == PH_ERR || prep_phase == PR_ERR)
  `MSB_ASSERT_NOW(a_start_loop, out_valid && start_cmd, main_phase == PH_LOOP && !stop_cmd)

endmodule

bind motor_start_brake_sequencer_core msb_checker u_msb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pwm_next   (out_ch.pwm_next),
  .start_cmd  (out_ch.start_cmd),
  .stop_cmd   (out_ch.stop_cmd),
  .error_on   (out_ch.error_on),
  .main_phase (out_ch.main_phase),
  .prep_phase (out_ch.prep_phase)
);
